/* design/rc4_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// shared types and constants for the rc4 stream cipher
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TableSize = 256;
  localparam int unsigned IdxW      = $clog2(TableSize);

  // one access bundle for the permutation table
  typedef struct packed {
    logic            clear;    // back to identity
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [ByteW-1:0] wr_data;
  } perm_req_t;

  // result handed to the output register
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } res_t;

endpackage : rc4_pkg
`default_nettype wire

/* design/rc4_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ram
// generic simple dual-port ram, registered read (read-first on collision)
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule : rc4_ram
`default_nettype wire

/* design/rc4_perm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_perm
// permutation table: ram plus per-entry valid bits, unwritten entries read as
// their own index so reset and clear give the identity at once
// ----------------------------------------------------------------------------
module rc4_perm
  import rc4_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire perm_req_t        req_i,
  output logic      [ByteW-1:0] rd_data_o
);

  logic [TableSize-1:0] valid_q;
  logic                 rd_valid_q;
  logic [IdxW-1:0]      rd_addr_q;
  logic [ByteW-1:0]     ram_rdata;

  rc4_ram #(
    .Width (ByteW),
    .Depth (TableSize)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (req_i.wr_en),
    .wr_addr_i (req_i.wr_addr),
    .wr_data_i (req_i.wr_data),
    .rd_en_i   (req_i.rd_en),
    .rd_addr_i (req_i.rd_addr),
    .rd_data_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
        rd_addr_q  <= req_i.rd_addr;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? ram_rdata : ByteW'(rd_addr_q);

endmodule : rc4_perm
`default_nettype wire

/* design/rc4_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ctrl
// sequencer: key collection, key schedule and keystream generation
// ----------------------------------------------------------------------------
module rc4_ctrl
  import rc4_pkg::*;
#(
  parameter  int unsigned MaxKeyBytes = 256,
  localparam int unsigned KeyAw       = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1,
  localparam int unsigned CntW        = $clog2(MaxKeyBytes + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             action_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             last_i,
  input  wire logic             out_free_i,
  output res_t                  res_o,
  output perm_req_t             perm_req_o,
  input  wire logic [ByteW-1:0] perm_rdata_i,
  output logic                  key_wr_en_o,
  output logic      [KeyAw-1:0] key_wr_addr_o,
  output logic      [ByteW-1:0] key_wr_data_o,
  output logic                  key_rd_en_o,
  output logic      [KeyAw-1:0] key_rd_addr_o,
  input  wire logic [ByteW-1:0] key_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DJ,
    ST_DSWI,
    ST_DSWJ,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_K3
  } state_e;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  gi_q, gi_d, gj_q, gj_d;
  logic [ByteW-1:0] si_q, si_d, sj_q, sj_d;
  logic [IdxW-1:0]  k_q, k_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  n_q, n_d;
  logic [ByteW-1:0] acc_q, acc_d;
  logic [KeyAw-1:0] kidx_q, kidx_d;

  logic accept;
  logic start;
  logic [ByteW-1:0] ks_byte;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign start      = accept && !action_i && last_i;

  // keystream byte with forwarding of the two swap writes
  always_comb begin
    if (k_q == gj_q) begin
      ks_byte = si_q;
    end else if (k_q == gi_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = perm_rdata_i;
    end
  end

  always_comb begin
    state_d = state_q;
    gi_d    = gi_q;
    gj_d    = gj_q;
    si_d    = si_q;
    sj_d    = sj_q;
    k_d     = k_q;
    byte_d  = byte_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    acc_d   = acc_q;
    kidx_d  = kidx_q;

    perm_req_o    = '0;
    res_o         = '0;
    key_wr_en_o   = 1'b0;
    key_wr_addr_o = cnt_q[KeyAw-1:0];
    key_wr_data_o = byte_i;
    key_rd_en_o   = 1'b0;
    key_rd_addr_o = kidx_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i) begin
            gi_d               = gi_q + IdxW'(1);
            byte_d             = byte_i;
            perm_req_o.rd_en   = 1'b1;
            perm_req_o.rd_addr = gi_d;
            state_d            = ST_DJ;
          end else begin
            if (cnt_q < CntW'(MaxKeyBytes)) begin
              key_wr_en_o = 1'b1;
              cnt_d       = cnt_q + CntW'(1);
            end
            if (last_i) begin
              perm_req_o.clear = 1'b1;
              n_d              = '0;
              acc_d            = '0;
              kidx_d           = '0;
              state_d          = ST_K0;
            end
          end
        end
      end
      ST_DJ: begin
        si_d               = perm_rdata_i;
        gj_d               = gj_q + IdxW'(perm_rdata_i);
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = gj_d;
        state_d            = ST_DSWI;
      end
      ST_DSWI: begin
        sj_d               = perm_rdata_i;
        k_d                = IdxW'(si_q + perm_rdata_i);
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = gi_q;
        perm_req_o.wr_data = perm_rdata_i;
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = k_d;
        state_d            = ST_DSWJ;
      end
      ST_DSWJ: begin
        // rewrite is harmless while the output register is full
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = gj_q;
        perm_req_o.wr_data = si_q;
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.data  = byte_q ^ ks_byte;
          state_d     = ST_IDLE;
        end
      end
      ST_K0: begin
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = n_q;
        key_rd_en_o        = 1'b1;
        state_d            = ST_K1;
      end
      ST_K1: begin
        si_d               = perm_rdata_i;
        acc_d              = ByteW'(acc_q + perm_rdata_i + key_rdata_i);
        perm_req_o.rd_en   = 1'b1;
        perm_req_o.rd_addr = IdxW'(acc_d);
        state_d            = ST_K2;
      end
      ST_K2: begin
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = n_q;
        perm_req_o.wr_data = perm_rdata_i;
        state_d            = ST_K3;
      end
      ST_K3: begin
        perm_req_o.wr_en   = 1'b1;
        perm_req_o.wr_addr = IdxW'(acc_q);
        perm_req_o.wr_data = si_q;
        n_d                = n_q + IdxW'(1);
        // key repeats cyclically over the bytes that were kept
        if ((CntW'(kidx_q) + CntW'(1)) >= cnt_q) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KeyAw'(1);
        end
        if (n_q == IdxW'(TableSize - 1)) begin
          gi_d    = '0;
          gj_d    = '0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_K0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gi_q    <= '0;
      gj_q    <= '0;
      si_q    <= '0;
      sj_q    <= '0;
      k_q     <= '0;
      byte_q  <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      acc_q   <= '0;
      kidx_q  <= '0;
    end else begin
      state_q <= state_d;
      gi_q    <= gi_d;
      gj_q    <= gj_d;
      si_q    <= si_d;
      sj_q    <= sj_d;
      k_q     <= k_d;
      byte_q  <= byte_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      acc_q   <= acc_d;
      kidx_q  <= kidx_d;
    end
  end

  // clearing and writing the table never coincide
  a_clear_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(perm_req_o.clear && perm_req_o.wr_en))
    else $error("table clear overlaps a write");

  // after it is taken, a data request passes ST_DJ and ST_DSWI and reaches the result step
  a_data_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i) |=> ##2 (state_q == ST_DSWJ))
    else $error("data request lost its sequence");

  // key byte count stays within the key store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxKeyBytes))
    else $error("key count beyond key store");

  // schedule always starts from round zero with a cleared accumulator
  a_sched_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (n_q == '0 && acc_q == '0 && kidx_q == '0))
    else $error("schedule started from a stale round");

  // the key index never passes the collected key length
  a_kidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K0) |-> (CntW'(kidx_q) < cnt_q))
    else $error("key index beyond key length");

endmodule : rc4_ctrl
`default_nettype wire

/* design/rc4_stream_cipher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// rc4 byte cipher: key bytes build the permutation, data bytes are xor-ed
// with the keystream
//
//   channel  dir  signals                      payload
//   s_*      in   s_tvalid_i / s_tready_o      tdata: byte_in, tuser: action,
//                                              tlast: key_last
//   m_*      out  m_tvalid_o / m_tready_i      tdata: byte_out
//
// a data request runs read s[i], read s[j], swap write with the keystream
// read, then the result; the single port pair of the table sets this order
// a key byte is stored as it is taken; the last key byte adds a key schedule
// (256 rounds of read, read, write, write on the same table)
// reset and every schedule start give the identity table at once through
// per-entry valid bits, no clearing pass
// a full output register holds a data request in its last step; key requests
// never wait on the output side
// ----------------------------------------------------------------------------
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // request side
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire logic [7:0] s_tdata_i,   // [7:0] byte_in
  input  wire logic [0:0] s_tuser_i,   // [0] action: 0 key byte, 1 data byte
  input  wire logic       s_tlast_i,   // key_last, final key byte
  // result side
  output logic            m_tvalid_o,
  input  wire logic       m_tready_i,
  output logic      [7:0] m_tdata_o    // [7:0] byte_out
);

  localparam int unsigned KeyAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  perm_req_t        perm_req;
  logic [ByteW-1:0] perm_rdata;
  res_t             res;
  logic             out_free;

  logic             key_wr_en;
  logic [KeyAw-1:0] key_wr_addr;
  logic [ByteW-1:0] key_wr_data;
  logic             key_rd_en;
  logic [KeyAw-1:0] key_rd_addr;
  logic [ByteW-1:0] key_rdata;

  logic             m_valid_q;
  logic [ByteW-1:0] m_data_q;

  // output register frees itself in the cycle it is taken
  assign out_free = !m_valid_q || m_tready_i;

  rc4_ctrl #(
    .MaxKeyBytes (MAX_KEY_BYTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid_i),
    .in_ready_o    (s_tready_o),
    .action_i      (s_tuser_i[0]),
    .byte_i        (s_tdata_i),
    .last_i        (s_tlast_i),
    .out_free_i    (out_free),
    .res_o         (res),
    .perm_req_o    (perm_req),
    .perm_rdata_i  (perm_rdata),
    .key_wr_en_o   (key_wr_en),
    .key_wr_addr_o (key_wr_addr),
    .key_wr_data_o (key_wr_data),
    .key_rd_en_o   (key_rd_en),
    .key_rd_addr_o (key_rd_addr),
    .key_rdata_i   (key_rdata)
  );

  // permutation table with identity on reset and on clear
  rc4_perm u_perm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (perm_req),
    .rd_data_o (perm_rdata)
  );

  // key store, only entries written since the last schedule are read
  rc4_ram #(
    .Width (ByteW),
    .Depth (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (key_wr_en),
    .wr_addr_i (key_wr_addr),
    .wr_data_i (key_wr_data),
    .rd_en_i   (key_rd_en),
    .rd_addr_i (key_rd_addr),
    .rd_data_o (key_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      m_data_q <= res.data;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule : rc4_stream_cipher
`default_nettype wire
